// ===== design/refcounted_buffer_pool_top_assert.svh =====
// assertion macros for the buffer pool
`ifndef REFCOUNTED_BUFFER_POOL_TOP_ASSERT_SVH
`define REFCOUNTED_BUFFER_POOL_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buffer pool assertion failed");
`define RBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buffer pool assertion failed");
`else
`define RBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define RBP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/rbp_pkg.sv =====
// constants and codes of the buffer pool
package rbp_pkg;

  localparam int unsigned CNT_W   = 8;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CLS_W   = 2;
  localparam int unsigned ARG_W   = 9;
  localparam int unsigned WANT_W  = 3;

  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADJUST = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADSLOT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [WANT_W-1:0] CLASS_SCREEN = 3'd4;
  localparam logic [WANT_W-1:0] CLASS_NONE   = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

// ===== design/refcounted_buffer_pool_top.sv =====
// reference-counted buffer pool, top level
//
// a request is transferred at a rising edge with start high and busy low;
// busy is high only while reset is applied and until a clock edge out of
// reset clears busy_r, so a new request can be transferred in every cycle
// request types: allocate (highest free slot of the wanted class, screen
// class when in_alloc_count is zero or negative), adjust a slot's count by
// in_count_delta with clamping at 0 and 255, and clear all counts
// every request gives exactly one result: out_granted_slot and out_status
// are shown for one cycle with out_valid high
// a request passes the input register, the combinational search and
// count update, and the result register; one request is taken per cycle
// reset clears all counts and drops any request in flight
// the receiver cannot stall: a result not taken in its cycle is gone
module refcounted_buffer_pool_top #(
  parameter int unsigned FULL_SLOTS   = 1,
  parameter int unsigned LARGE_SLOTS  = 3,
  parameter int unsigned MEDIUM_SLOTS = 3,
  parameter int unsigned SMALL_SLOTS  = 3,
  parameter int unsigned TOTAL_SLOTS  = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rbp_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [rbp_pkg::ARG_W-1:0]    in_alloc_count,
  input  logic [rbp_pkg::CLS_W-1:0]           in_size_class,
  input  logic [rbp_pkg::SLOT_W-1:0]          in_slot_index,
  input  logic signed [rbp_pkg::ARG_W-1:0]    in_count_delta,
  output logic                                out_valid,
  output logic [rbp_pkg::SLOT_W-1:0]          out_granted_slot,
  output logic [rbp_pkg::STAT_W-1:0]          out_status
);
  import rbp_pkg::*;

  localparam int unsigned SCREEN_SLOTS = 1;
  localparam int unsigned B0 = SCREEN_SLOTS;
  localparam int unsigned B1 = B0 + FULL_SLOTS;
  localparam int unsigned B2 = B1 + LARGE_SLOTS;
  localparam int unsigned B3 = B2 + MEDIUM_SLOTS;
  localparam int unsigned B4 = B3 + SMALL_SLOTS;
  localparam int unsigned IDX_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

  function automatic logic [WANT_W-1:0] slot_class(input int unsigned s);
    logic [WANT_W-1:0] c;
    if (s < B0) c = CLASS_SCREEN;
    else if (s < B1) c = 3'd0;
    else if (s < B2) c = 3'd1;
    else if (s < B3) c = 3'd2;
    else if (s < B4) c = 3'd3;
    else c = CLASS_NONE;
    return c;
  endfunction

  logic                    busy_r;
  logic                    req_valid_r;
  logic [REQ_W-1:0]        req_type_r;
  logic signed [ARG_W-1:0] alloc_count_r;
  logic [CLS_W-1:0]        size_class_r;
  logic [SLOT_W-1:0]       slot_index_r;
  logic signed [ARG_W-1:0] count_delta_r;

  cnt_t                    cnt_r [TOTAL_SLOTS];
  cnt_t                    cnt_nxt [TOTAL_SLOTS];

  logic                    out_valid_r;
  logic [SLOT_W-1:0]       out_granted_slot_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [SLOT_W-1:0]       granted_nxt;
  logic [STAT_W-1:0]       status_nxt;

  logic                    accept;
  logic [WANT_W-1:0]       want;
  logic signed [ARG_W:0]   neg_count;
  cnt_t                    init_count;
  logic                    found;
  logic [IDX_W-1:0]        found_idx;
  logic                    slot_ok;
  logic [IDX_W-1:0]        adj_idx;
  logic signed [ARG_W:0]   adj_sum;
  logic                    all_zero;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      req_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      req_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r    <= in_req_type;
      alloc_count_r <= in_alloc_count;
      size_class_r  <= in_size_class;
      slot_index_r  <= in_slot_index;
      count_delta_r <= in_count_delta;
    end
  end

  // allocate: wanted class and initial count
  always_comb begin
    neg_count = -{alloc_count_r[ARG_W-1], alloc_count_r};
    if (alloc_count_r <= 0) begin
      want = CLASS_SCREEN;
      if (neg_count[ARG_W-1]) init_count = CNT_MAX;
      else init_count = neg_count[CNT_W-1:0];
    end else begin
      want       = {1'b0, size_class_r};
      init_count = alloc_count_r[CNT_W-1:0];
    end
  end

  // highest free slot of the wanted class
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      if (slot_class(i) == want && cnt_r[i] == '0) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // adjust: clamped sum
  assign slot_ok = {1'b0, slot_index_r} < (SLOT_W+1)'(TOTAL_SLOTS);
  assign adj_idx = slot_index_r[IDX_W-1:0];
  assign adj_sum = $signed({2'b00, cnt_r[adj_idx]}) + {count_delta_r[ARG_W-1], count_delta_r};

  always_comb begin
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    granted_nxt = '0;
    status_nxt  = ST_OK;
    if (req_valid_r) begin
      unique case (req_type_r)
        REQ_ALLOC: begin
          if (found) begin
            cnt_nxt[found_idx] = init_count;
            granted_nxt        = SLOT_W'(found_idx);
          end else begin
            status_nxt = ST_EXHAUSTED;
          end
        end
        REQ_ADJUST: begin
          if (!slot_ok) begin
            status_nxt = ST_BADSLOT;
          end else if (adj_sum < 0) begin
            cnt_nxt[adj_idx] = '0;
            status_nxt       = ST_UNDERFLOW;
          end else if (adj_sum > $signed({2'b00, CNT_MAX})) begin
            cnt_nxt[adj_idx] = CNT_MAX;
          end else begin
            cnt_nxt[adj_idx] = adj_sum[CNT_W-1:0];
          end
        end
        REQ_CLEAR: begin
          for (int i = 0; i < TOTAL_SLOTS; i++) begin
            cnt_nxt[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      out_valid_r <= req_valid_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_granted_slot_r <= granted_nxt;
    out_status_r       <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_granted_slot_r;
  assign out_status       = out_status_r;

  always_comb begin
    all_zero = 1'b1;
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      if (cnt_r[i] != '0) all_zero = 1'b0;
    end
  end

`include "refcounted_buffer_pool_top_assert.svh"

  `RBP_ASSERT_NEXT(a_req_to_result, clk, rst_n, req_valid_r, out_valid_r)
  `RBP_ASSERT_NEXT(a_accept_to_req, clk, rst_n, accept, req_valid_r)
  `RBP_ASSERT_SAME(a_exhausted_slot0, clk, rst_n, out_valid_r && out_status_r == ST_EXHAUSTED, out_granted_slot_r == '0)
  `RBP_ASSERT_NEXT(a_clear_zeroes, clk, rst_n, req_valid_r && req_type_r == REQ_CLEAR, all_zero)

endmodule
